/* hdl/ntab_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ntab_pkg;

   localparam int TABLE_DEPTH     = 16;
   localparam int ADDR_W          = 48;
   localparam int TIME_W          = 32;
   localparam int CNT_W           = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W         = 5;
   localparam int ENTRY_MAX       = 31;
   localparam logic [TIME_W-1:0] AGE_LIMIT_RESET = 32'd5000;

   typedef enum logic {
      OP_BEACON = 1'b0,
      OP_SWEEP  = 1'b1
   } op_type;

   // contents of one table slot
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic [TIME_W-1:0] heard;
   } ntab_slot_type;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic              look;
      logic              apply;
      logic              sweep;
      logic              hit_any;
      logic              full;
      logic [ADDR_W-1:0] addr;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] age_limit;
   } ntab_cell_ctrl_type;

endpackage
`default_nettype wire

/* hdl/ntab_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface ntab_req_if;
   import ntab_pkg::*;

   logic              valid;
   logic              ready;
   logic              operation;
   logic [ADDR_W-1:0] neighbor_address;
   logic [TIME_W-1:0] current_time;

   modport source (output valid, output operation, output neighbor_address,
                   output current_time, input ready);
   modport sink   (input valid, input operation, input neighbor_address,
                   input current_time, output ready);
endinterface
`default_nettype wire

/* hdl/ntab_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface ntab_rsp_if;
   import ntab_pkg::*;

   logic               valid;
   logic               ready;
   logic               was_known;
   logic               inserted;
   logic               dropped_full;
   logic               removed;
   logic [ADDR_W-1:0]  removed_address;
   logic [ENTRY_W-1:0] entry_count;

   modport source (output valid, output was_known, output inserted,
                   output dropped_full, output removed, output removed_address,
                   output entry_count, input ready);
   modport sink   (input valid, input was_known, input inserted,
                   input dropped_full, input removed, input removed_address,
                   input entry_count, output ready);
endinterface
`default_nettype wire

/* hdl/ntab_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module ntab_cell
   import ntab_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ntab_cell_ctrl_type ctrl,
   input  wire ntab_slot_type      slot_up,
   input  wire logic               valid_below,
   input  wire logic               prefix_in,
   output      ntab_slot_type      slot_out,
   output      logic               prefix_out,
   output      logic [ADDR_W-1:0]  removed_addr
);

   ntab_slot_type     slot_ff, slot_in;
   logic              flag_ff, flag_in;
   logic [TIME_W-1:0] age;
   logic              sel;

   assign age        = ctrl.now - slot_ff.heard;
   assign sel        = flag_ff & ~prefix_in;
   assign prefix_out = prefix_in | flag_ff;
   assign slot_out   = slot_ff;
   assign removed_addr = (ctrl.sweep && sel) ? slot_ff.addr : '0;

   always_comb begin
      flag_in = flag_ff;
      if (ctrl.look) begin
         if (ctrl.sweep) begin
            flag_in = slot_ff.valid & (age >= ctrl.age_limit);
         end else begin
            flag_in = slot_ff.valid & (slot_ff.addr == ctrl.addr);
         end
      end
   end

   always_comb begin
      slot_in = slot_ff;
      if (ctrl.apply) begin
         if (ctrl.sweep) begin
            // close the gap: every cell from the removed one upward takes its neighbour
            if (prefix_out) begin
               slot_in = slot_up;
            end
         end else if (sel) begin
            slot_in.heard = ctrl.now;
         end else if (!ctrl.hit_any && !ctrl.full && valid_below && !slot_ff.valid) begin
            slot_in.valid = 1'b1;
            slot_in.addr  = ctrl.addr;
            slot_in.heard = ctrl.now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
         flag_ff       <= 1'b0;
      end else begin
         slot_ff.valid <= slot_in.valid;
         flag_ff       <= flag_in;
      end
      slot_ff.addr  <= slot_in.addr;
      slot_ff.heard <= slot_in.heard;
   end

endmodule
`default_nettype wire

/* hdl/neighbor_table_with_aging_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Ordered neighbour table of TABLE_DEPTH slots, each a cell holding an address and a
// last-heard time. A beat on req_bus is either a beacon (refresh on hit, append on miss,
// flag when full) or a sweep (remove the first slot whose age reaches csr age_limit and
// shift the later slots down). Every item passes through three steps: ST_IDLE captures the
// beat, ST_LOOK compares in all cells at once, and ST_APPLY runs the first-hit chain through
// the cells and the update. The result is registered at the update, and the next beat can
// be accepted once the core is back in ST_IDLE. req_bus.ready is high while no
// item is in work; the result sits in an output register, so the next beat can be accepted
// while it waits, and the update cycle holds until that register is free. No clearing pass.
module neighbor_table_with_aging_core
   import ntab_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   ntab_req_if.sink               req_bus,
   ntab_rsp_if.source             rsp_bus,
   input  wire logic              csr_wr_en,
   input  wire logic [TIME_W-1:0] csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_LOOK  = 3'b010,
      ST_APPLY = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [TIME_W-1:0]  age_limit_ff;
   logic               op_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               out_free, do_apply;

   logic               rsp_valid_ff;
   logic               known_ff, inserted_ff, dropped_ff, removed_ff;
   logic [ADDR_W-1:0]  rem_addr_ff;
   logic [ENTRY_W-1:0] entry_ff;

   ntab_cell_ctrl_type ctrl;
   ntab_slot_type      slots [TABLE_DEPTH];
   logic [ADDR_W-1:0]  rem_addrs [TABLE_DEPTH];
   logic [TABLE_DEPTH:0] prefix;
   logic [ADDR_W-1:0]  rem_addr_all;
   logic               hit_any, full;
   logic [CNT_W+ENTRY_W-1:0] count_wide;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign out_free      = ~rsp_valid_ff | rsp_bus.ready;
   assign do_apply      = (state_ff == ST_APPLY) && out_free;
   assign hit_any       = prefix[TABLE_DEPTH];
   assign full          = slots[TABLE_DEPTH-1].valid;
   assign prefix[0]     = 1'b0;

   assign ctrl.look      = (state_ff == ST_LOOK);
   assign ctrl.apply     = do_apply;
   assign ctrl.sweep     = (op_ff == OP_SWEEP);
   assign ctrl.hit_any   = hit_any;
   assign ctrl.full      = full;
   assign ctrl.addr      = addr_ff;
   assign ctrl.now       = now_ff;
   assign ctrl.age_limit = age_limit_ff;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      ntab_slot_type up;
      logic          below;
      if (g == TABLE_DEPTH - 1) begin : g_top
         assign up = '0;
      end else begin : g_mid
         assign up = slots[g+1];
      end
      if (g == 0) begin : g_first
         assign below = 1'b1;
      end else begin : g_rest
         assign below = slots[g-1].valid;
      end
      ntab_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .slot_up      (up),
         .valid_below  (below),
         .prefix_in    (prefix[g]),
         .slot_out     (slots[g]),
         .prefix_out   (prefix[g+1]),
         .removed_addr (rem_addrs[g])
      );
   end

   always_comb begin
      rem_addr_all = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         rem_addr_all = rem_addr_all | rem_addrs[i];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_bus.valid) state_in = ST_LOOK;
         ST_LOOK:  state_in = ST_APPLY;
         ST_APPLY: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.sweep) begin
         if (hit_any) count_in = count_ff - CNT_W'(1);
      end else if (!hit_any && !full) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   assign count_wide = (CNT_W+ENTRY_W)'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         age_limit_ff <= AGE_LIMIT_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) age_limit_ff <= csr_wr_data;
         if (do_apply) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         op_ff   <= req_bus.operation;
         addr_ff <= req_bus.neighbor_address;
         now_ff  <= req_bus.current_time;
      end
      if (do_apply) begin
         known_ff    <= ~ctrl.sweep & hit_any;
         inserted_ff <= ~ctrl.sweep & ~hit_any & ~full;
         dropped_ff  <= ~ctrl.sweep & ~hit_any & full;
         removed_ff  <= ctrl.sweep & hit_any;
         rem_addr_ff <= rem_addr_all;
         entry_ff    <= (count_wide > (CNT_W+ENTRY_W)'(ENTRY_MAX)) ?
                        ENTRY_W'(ENTRY_MAX) : count_wide[ENTRY_W-1:0];
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.was_known       = known_ff;
   assign rsp_bus.inserted        = inserted_ff;
   assign rsp_bus.dropped_full    = dropped_ff;
   assign rsp_bus.removed         = removed_ff;
   assign rsp_bus.removed_address = rem_addr_ff;
   assign rsp_bus.entry_count     = entry_ff;

endmodule
`default_nettype wire

/* hdl/ntab_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module ntab_checker
   import ntab_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               was_known,
   input wire logic               inserted,
   input wire logic               dropped_full,
   input wire logic               removed,
   input wire logic [ADDR_W-1:0]  removed_address,
   input wire logic [ENTRY_W-1:0] entry_count
);

   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({was_known, inserted, dropped_full, removed}))
      else $error("more than one outcome flag in a result beat");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(entry_count) <= TABLE_DEPTH))
      else $error("entry_count exceeds table depth");

   a_rem_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !removed) |-> (removed_address == '0))
      else $error("removed_address set without a removal");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && inserted) |-> (entry_count != '0))
      else $error("insertion reported with an empty table");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(entry_count)
                                     && $stable(removed_address)))
      else $error("stalled result beat changed");

endmodule

bind neighbor_table_with_aging_core ntab_checker u_ntab_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .was_known       (rsp_bus.was_known),
   .inserted        (rsp_bus.inserted),
   .dropped_full    (rsp_bus.dropped_full),
   .removed         (rsp_bus.removed),
   .removed_address (rsp_bus.removed_address),
   .entry_count     (rsp_bus.entry_count)
);
`default_nettype wire
